[sv/vector3_normalize_assert.svh]
`ifndef VECTOR3_NORMALIZE_ASSERT_SVH
`define VECTOR3_NORMALIZE_ASSERT_SVH

// Clocked implication check, off while reset is held.
`define V3N_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vector3_normalize check failed");

// Check that holds at every edge out of reset.
`define V3N_ASSERT_ALW(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("vector3_normalize check failed");

`endif

[sv/v3n_pkg.sv]
package v3n_pkg;

  localparam int unsigned CompW    = 32;
  localparam int unsigned SumW     = 2 * CompW;
  localparam int unsigned QuoW     = 31;
  localparam int unsigned SqStages = CompW;
  localparam int unsigned DivStages = QuoW;
  localparam int unsigned Latency  = 3 + SqStages + DivStages + 1;

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } v3n_meta_t;

endpackage

[sv/v3n_isqrt.sv]
module v3n_isqrt import v3n_pkg::*; (
  input  logic                clk,
  input  logic [SumW-1:0]     sum,
  output logic [CompW-1:0]    root
);

  logic [SumW-1:0]  n_s    [SqStages+1];
  logic [CompW+1:0] rem_s  [SqStages+1];
  logic [CompW-1:0] root_s [SqStages+1];

  assign n_s[0]    = sum;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;

  for (genvar i = 0; i < SqStages; i++) begin : g_stage
    logic [CompW+3:0] rem_sh;
    logic [CompW+3:0] trial;
    logic             take;

    always_comb begin
      rem_sh = {rem_s[i], n_s[i][SumW-1 -: 2]};
      trial  = {2'b00, root_s[i], 2'b01};
      take   = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      n_s[i+1]    <= {n_s[i][SumW-3:0], 2'b00};
      rem_s[i+1]  <= take ? CompW'(0) + (rem_sh[CompW+1:0] - trial[CompW+1:0])
                          : rem_sh[CompW+1:0];
      root_s[i+1] <= {root_s[i][CompW-2:0], take};
    end
  end

  assign root = root_s[SqStages];

endmodule

[sv/v3n_div_lane.sv]
module v3n_div_lane import v3n_pkg::*; (
  input  logic             clk,
  input  logic [CompW-1:0] mag_in,
  input  logic [CompW-1:0] divisor,
  output logic [QuoW-1:0]  quo
);

  // dividend is mag_in << 30; the quotient never exceeds 2^30
  logic [CompW-1:0] rem_s [DivStages+1];
  logic [QuoW-1:0]  dbit_s [DivStages+1];
  logic [QuoW-1:0]  quo_s [DivStages+1];
  logic [CompW-1:0] dvs_s [DivStages+1];

  assign rem_s[0]  = {1'b0, mag_in[CompW-1:1]};
  assign dbit_s[0] = {mag_in[0], {(QuoW-1){1'b0}}};
  assign quo_s[0]  = '0;
  assign dvs_s[0]  = divisor;

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    logic [CompW:0] rem_sh;
    logic           take;

    always_comb begin
      rem_sh = {rem_s[k], dbit_s[k][QuoW-1]};
      take   = (rem_sh >= {1'b0, dvs_s[k]});
    end

    always_ff @(posedge clk) begin
      rem_s[k+1]  <= take ? CompW'(rem_sh - {1'b0, dvs_s[k]}) : rem_sh[CompW-1:0];
      dbit_s[k+1] <= {dbit_s[k][QuoW-2:0], 1'b0};
      quo_s[k+1]  <= {quo_s[k][QuoW-2:0], take};
      dvs_s[k+1]  <= dvs_s[k];
    end
  end

  assign quo = quo_s[DivStages];

endmodule

[sv/vector3_normalize.sv]
// Channel  | Ports                                   | Handshake
// input    | in_x_comp, in_y_comp, in_z_comp         | start high, busy low
// result   | out_unit_x/y/z, out_length, out_zero_vector | out_valid, one cycle
// One word enters per cycle; busy never rises.
// A result passes 3 squaring/sum stages,
// 32 root stages (one bit each) and 31 divide stages per lane, plus merge.
// Synchronous active-low reset clears the valid pipeline only.
// The receiver cannot stall; results leave on their fixed cycle.
module vector3_normalize import v3n_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [CompW-1:0] in_x_comp,
  input  logic signed [CompW-1:0] in_y_comp,
  input  logic signed [CompW-1:0] in_z_comp,
  output logic                    out_valid,
  output logic signed [CompW-1:0] out_unit_x,
  output logic signed [CompW-1:0] out_unit_y,
  output logic signed [CompW-1:0] out_unit_z,
  output logic        [CompW-1:0] out_length,
  output logic                    out_zero_vector
);

  localparam int unsigned MidDly = SqStages;
  localparam int unsigned MetaDly = SqStages + DivStages;

  logic [Latency-2:0] vld_r;
  logic [Latency-2:0] vld_nxt;
  logic               out_valid_r;

  logic [CompW-1:0]   abs_r [3];
  logic [CompW-1:0]   abs2_r [3];
  logic [SumW-1:0]    sq_r [3];
  logic [SumW-1:0]    sum_r;
  v3n_meta_t          meta_r, meta2_r, meta3_r;
  logic [CompW-1:0]   abs3_r [3];
  logic [CompW-1:0]   absd_r [MidDly][3];
  v3n_meta_t          metad_r [MetaDly];
  logic [CompW-1:0]   root;
  logic [CompW-1:0]   magd_r [DivStages];
  logic [QuoW-1:0]    quo [3];
  logic [CompW-1:0]   unit_r [3];
  logic [CompW-1:0]   len_r;
  logic               zero_r;
  logic signed [CompW-1:0] in_c [3];

  assign busy   = 1'b0;
  assign in_c[0] = in_x_comp;
  assign in_c[1] = in_y_comp;
  assign in_c[2] = in_z_comp;

  always_comb begin
    vld_nxt = {vld_r[Latency-3:0], start & ~busy};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[Latency-2];
    end
  end

  // front: magnitudes, squares, sum
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      abs_r[i]      <= in_c[i][CompW-1] ? CompW'(-in_c[i]) : in_c[i];
      meta_r.neg[i] <= in_c[i][CompW-1];
      sq_r[i]       <= abs_r[i] * abs_r[i];
      abs2_r[i]     <= abs_r[i];
      abs3_r[i]     <= abs2_r[i];
    end
    meta_r.zero <= (in_x_comp == '0) && (in_y_comp == '0) && (in_z_comp == '0);
    meta2_r     <= meta_r;
    sum_r       <= sq_r[0] + sq_r[1] + sq_r[2];
    meta3_r     <= meta2_r;
  end

  v3n_isqrt u_isqrt (
    .clk  (clk),
    .sum  (sum_r),
    .root (root)
  );

  // hold operands alongside the root and divide pipelines
  always_ff @(posedge clk) begin
    absd_r[0] <= abs3_r;
    for (int s = 1; s < MidDly; s++) absd_r[s] <= absd_r[s-1];
    metad_r[0] <= meta3_r;
    for (int s = 1; s < MetaDly; s++) metad_r[s] <= metad_r[s-1];
    magd_r[0] <= root;
    for (int s = 1; s < DivStages; s++) magd_r[s] <= magd_r[s-1];
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    v3n_div_lane u_lane (
      .clk     (clk),
      .mag_in  (absd_r[MidDly-1][l]),
      .divisor (root),
      .quo     (quo[l])
    );
  end

  // merge: apply signs, force zero vector
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (metad_r[MetaDly-1].zero) unit_r[i] <= '0;
      else if (metad_r[MetaDly-1].neg[i]) unit_r[i] <= CompW'(-{1'b0, quo[i]});
      else unit_r[i] <= {1'b0, quo[i]};
    end
    len_r  <= metad_r[MetaDly-1].zero ? '0 : magd_r[DivStages-1];
    zero_r <= metad_r[MetaDly-1].zero;
  end

  assign out_valid       = out_valid_r;
  assign out_unit_x      = unit_r[0];
  assign out_unit_y      = unit_r[1];
  assign out_unit_z      = unit_r[2];
  assign out_length      = len_r;
  assign out_zero_vector = zero_r;

`include "vector3_normalize_assert.svh"

  `V3N_ASSERT_ALW(a_never_busy, !busy)
  `V3N_ASSERT_IMP(a_zero_out, out_valid && out_zero_vector,
    out_length == '0 && out_unit_x == '0 && out_unit_y == '0 && out_unit_z == '0)
  `V3N_ASSERT_IMP(a_len_nonzero, out_valid && !out_zero_vector, out_length != '0)
  `V3N_ASSERT_IMP(a_unit_range, out_valid,
    out_unit_x <= 32'sd1073741824 && out_unit_x >= -32'sd1073741824)

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
  import v3n_pkg::*;

  typedef struct {
    logic signed [CompW-1:0] x;
    logic signed [CompW-1:0] y;
    logic signed [CompW-1:0] z;
  } vec_word_t;

  typedef struct {
    logic signed [CompW-1:0] ux;
    logic signed [CompW-1:0] uy;
    logic signed [CompW-1:0] uz;
    logic        [CompW-1:0] len;
    logic                    zero;
  } unit_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CompW-1:0] in_x_comp = '0;
  logic signed [CompW-1:0] in_y_comp = '0;
  logic signed [CompW-1:0] in_z_comp = '0;
  logic out_valid;
  logic signed [CompW-1:0] out_unit_x, out_unit_y, out_unit_z;
  logic [CompW-1:0] out_length;
  logic out_zero_vector;

  vec_word_t  vec_queue[$];
  unit_word_t unit_queue[$];
  int unsigned err_count = 0;
  bit stim_done = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  vector3_normalize u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_x_comp(in_x_comp), .in_y_comp(in_y_comp), .in_z_comp(in_z_comp),
    .out_valid(out_valid), .out_unit_x(out_unit_x), .out_unit_y(out_unit_y),
    .out_unit_z(out_unit_z), .out_length(out_length),
    .out_zero_vector(out_zero_vector)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] mag32(logic signed [CompW-1:0] c);
    logic [63:0] v;
    v = {32'd0, c};
    if (c[CompW-1]) v = 64'h1_0000_0000 - v;
    return v;
  endfunction

  function automatic logic [63:0] int_root(logic [63:0] n);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [CompW-1:0] scaled_ratio(logic signed [CompW-1:0] c,
                                                    logic [63:0] m);
    logic [63:0] q;
    q = (mag32(c) << 30) / m;
    if (c[CompW-1]) q = 64'h1_0000_0000 - q;
    return q[CompW-1:0];
  endfunction

  function automatic unit_word_t normalize(vec_word_t v);
    unit_word_t r;
    logic [63:0] ax, ay, az, m;
    ax = mag32(v.x);
    ay = mag32(v.y);
    az = mag32(v.z);
    m = int_root(ax * ax + ay * ay + az * az);
    if (m == 0) begin
      r = '{0, 0, 0, 0, 1'b1};
    end else begin
      r.ux = scaled_ratio(v.x, m);
      r.uy = scaled_ratio(v.y, m);
      r.uz = scaled_ratio(v.z, m);
      r.len = m[CompW-1:0];
      r.zero = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [CompW-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 255) - 128;
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return 32'h7fff_ffff - $urandom_range(0, 3);
      3: return $urandom >> $urandom_range(0, 31);
      4: return -($urandom >> $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  task automatic push_vec(logic [CompW-1:0] x, logic [CompW-1:0] y,
                          logic [CompW-1:0] z);
    vec_word_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    vec_queue.push_back(v);
  endtask

  initial begin
    push_vec(0, 0, 0);
    push_vec(32'h8000_0000, 0, 0);
    push_vec(0, 32'h8000_0000, 0);
    push_vec(0, 0, 32'h8000_0000);
    push_vec(32'h7fff_ffff, 0, 0);
    push_vec(0, 32'h7fff_ffff, 0);
    push_vec(0, 0, 32'h7fff_ffff);
    push_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    push_vec(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    push_vec(1, 0, 0);
    push_vec(0, -1, 0);
    push_vec(0, 0, 1);
    push_vec(1, 1, 1);
    push_vec(-1, -1, -1);
    push_vec(32'h0001_0000, 32'h0001_0000, 0);
    push_vec(32'hffff_ffff, 32'h7fff_ffff, 1);
    push_vec(0, 0, 0);
    repeat (900) begin
      if ($urandom_range(0, 19) == 0) push_vec(0, 0, 0);
      else push_vec(rand_comp(), rand_comp(), rand_comp());
    end
    stim_done = 1'b1;
  end

  // Driver: bursts of words with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // hold the word until taken
    end else begin
      // drop the word taken at this edge; the next one is then at the head
      if (start) void'(vec_queue.pop_front());
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (vec_queue.size() > 0) begin
        vec_word_t v;
        v = vec_queue[0];
        start <= 1'b1;
        in_x_comp <= v.x;
        in_y_comp <= v.y;
        in_z_comp <= v.z;
        unit_queue.push_back(normalize(v));
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobe must match the oldest expected word.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (unit_queue.size() == 0) begin
        $error("unexpected result word");
        err_count++;
      end else begin
        unit_word_t e;
        e = unit_queue.pop_front();
        if (out_unit_x !== e.ux) begin
          $error("unit_x exp %0d got %0d", e.ux, out_unit_x); err_count++;
        end
        if (out_unit_y !== e.uy) begin
          $error("unit_y exp %0d got %0d", e.uy, out_unit_y); err_count++;
        end
        if (out_unit_z !== e.uz) begin
          $error("unit_z exp %0d got %0d", e.uz, out_unit_z); err_count++;
        end
        if (out_length !== e.len) begin
          $error("length exp %0d got %0d", e.len, out_length); err_count++;
        end
        if (out_zero_vector !== e.zero) begin
          $error("zero_vector exp %0d got %0d", e.zero, out_zero_vector);
          err_count++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done);
    while (vec_queue.size() > 0 || start) @(posedge clk);
    while (unit_queue.size() > 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    if (err_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
